FILE: design/ccsc_pkg.sv
// ----------------------------------------------------------------------------
// ccsc_pkg - shared types and constants for the ChaCha20 stream cipher unit
// Beat structs, FSM states, config register indexes, round-step codes.
// ----------------------------------------------------------------------------
package ccsc_pkg;

  localparam int unsigned NumWords  = 16;
  localparam int unsigned NumRounds = 20;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;

  typedef logic [31:0]               word_t;
  typedef logic [NumWords-1:0][31:0] block_t;

  // "expand 32-byte k"
  localparam word_t SIGMA0 = 32'h6170_7865;
  localparam word_t SIGMA1 = 32'h3320_646e;
  localparam word_t SIGMA2 = 32'h7962_2d32;
  localparam word_t SIGMA3 = 32'h6b20_6574;

  localparam logic [4:0] LAST_ROUND = 5'(NumRounds - 1);
  localparam logic [3:0] LAST_WORD  = 4'(NumWords - 1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY0     = 3'd0,
    CFG_KEY1     = 3'd1,
    CFG_KEY2     = 3'd2,
    CFG_KEY3     = 3'd3,
    CFG_NONCE_LO = 3'd4,
    CFG_NONCE_HI = 3'd5,
    CFG_START    = 3'd6
  } cfg_idx_t;

  // one quarter-round split into its four add/xor/rotate steps
  typedef enum logic [1:0] {
    QS_AB16 = 2'd0,
    QS_CD12 = 2'd1,
    QS_AB8  = 2'd2,
    QS_CD7  = 2'd3
  } qstep_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GEN,
    ST_STORE,
    ST_FETCH,
    ST_XOR
  } state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] result_byte;
    logic       last_out;
  } out_beat_t;

  typedef struct packed {
    logic start;
  } core_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  function automatic word_t rotl(word_t v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

endpackage

FILE: design/ccsc_round_core.sv
// ----------------------------------------------------------------------------
// ccsc_round_core - ChaCha20 round engine
// Holds the 16-word working state; one quarter-round step per cycle on all
// four lanes, 4 steps per round, 20 rounds.
// ----------------------------------------------------------------------------
module ccsc_round_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ccsc_pkg::core_ctrl_t ctrl_i,
  input  ccsc_pkg::block_t     init_i,
  output ccsc_pkg::block_t     work_o,
  output ccsc_pkg::core_stat_t stat_o
);
  import ccsc_pkg::*;

  block_t     w_r;
  block_t     w_nxt;
  logic [4:0] round_r;
  qstep_t     step_r;
  logic       busy_r;
  logic       done_r;
  logic       last_step;

  assign last_step = (round_r == LAST_ROUND) && (step_r == QS_CD7);

  // odd rounds are diagonal: rows b, c, d shift left by 1, 2, 3 lanes
  always_comb begin
    logic  diag;
    word_t a, b, c, d, sum, mixv, rot;
    w_nxt = w_r;
    diag  = round_r[0];
    for (int j = 0; j < 4; j++) begin
      a = w_r[j];
      b = diag ? w_r[4 + ((j + 1) % 4)]  : w_r[4 + j];
      c = diag ? w_r[8 + ((j + 2) % 4)]  : w_r[8 + j];
      d = diag ? w_r[12 + ((j + 3) % 4)] : w_r[12 + j];
      sum  = step_r[0] ? (c + d) : (a + b);
      mixv = step_r[0] ? (b ^ sum) : (d ^ sum);
      unique case (step_r)
        QS_AB16: rot = rotl(mixv, 16);
        QS_CD12: rot = rotl(mixv, 12);
        QS_AB8:  rot = rotl(mixv, 8);
        QS_CD7:  rot = rotl(mixv, 7);
        default: rot = mixv;
      endcase
      if (step_r[0]) begin
        c = sum;
        b = rot;
      end else begin
        a = sum;
        d = rot;
      end
      w_nxt[j] = a;
      if (diag) begin
        w_nxt[4 + ((j + 1) % 4)]  = b;
        w_nxt[8 + ((j + 2) % 4)]  = c;
        w_nxt[12 + ((j + 3) % 4)] = d;
      end else begin
        w_nxt[4 + j]  = b;
        w_nxt[8 + j]  = c;
        w_nxt[12 + j] = d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      round_r <= '0;
      step_r  <= QS_AB16;
    end else begin
      done_r <= busy_r && last_step;
      if (ctrl_i.start) begin
        busy_r  <= 1'b1;
        round_r <= '0;
        step_r  <= QS_AB16;
      end else if (busy_r) begin
        step_r <= qstep_t'(2'(step_r + 2'd1));
        if (step_r == QS_CD7 && !last_step) begin
          round_r <= round_r + 5'd1;
        end
        if (last_step) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.start) begin
      w_r <= init_i;
    end else if (busy_r) begin
      w_r <= w_nxt;
    end
  end

  assign work_o      = w_r;
  assign stat_o.busy = busy_r;
  assign stat_o.done = done_r;

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    round_r <= LAST_ROUND)
    else $error("round counter out of range");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_i.start |-> !busy_r)
    else $error("start while rounds in progress");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("done without finishing rounds");

endmodule

FILE: design/chacha20_stream_cipher_unit.sv
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_unit - ChaCha20 (RFC 8439) byte-stream cipher
// XORs each byte with the next keystream byte; keystream block kept in a
// 16 x 32 synchronous RAM, refilled by the round core when used up.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat payload                  | handshake
//  --------+-----+-------------------------------+----------------------
//  in_     | in  | in_beat_t  {data_byte,last_in} | in_valid / in_ready
//  out_    | out | out_beat_t {result_byte,last}  | out_valid / out_ready
//  cfg_    | in  | cfg_index (3), cfg_data (64)   | cfg_valid / cfg_ready
//
//  A byte from the buffered block is accepted with its RAM read, then XORed
//  before the next byte is taken. A byte that opens a new block first waits
//  for all 20 rounds of round steps, done, 16 feed-forward writes into the
//  keystream RAM and a RAM read.
//  Reset: counter 0, config 0, keystream empty. RAM contents are not cleared.
//  Stalls: out_ready low holds the XOR stage while the previous result is pending; in_ready is low outside IDLE.
//  cfg_ready is always high; writes are expected only while idle.
//
module chacha20_stream_cipher_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // input byte stream
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ccsc_pkg::in_beat_t              in_data,
  // result byte stream
  output logic                            out_valid,
  input  logic                            out_ready,
  output ccsc_pkg::out_beat_t             out_data,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ccsc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [ccsc_pkg::CfgDataW-1:0]   cfg_data
);
  import ccsc_pkg::*;

  // configuration registers
  logic [3:0][63:0] key_r;
  logic [63:0]      nonce_lo_r;
  logic [31:0]      nonce_hi_r;
  logic [31:0]      start_ctr_r;

  // stream state
  state_t      state_r, state_nxt;
  logic [31:0] counter_r;
  logic [6:0]  pos_r;       // 0..64, 64 = keystream empty
  logic [3:0]  store_idx_r;
  in_beat_t    in_r;
  out_beat_t   out_r;
  logic        out_valid_r;

  // keystream RAM with a registered read port
  word_t       ks_mem [NumWords];
  word_t       rd_r;

  // control
  logic        in_fire, cfg_fire, cfg_hit, out_free;
  logic        rd_en, mem_we, out_load;
  core_ctrl_t  core_ctrl;
  core_stat_t  core_stat;
  block_t      init_w, work_w;
  word_t       ff_word;
  logic [7:0]  ks_byte;

  assign in_fire  = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign cfg_hit  = cfg_fire && (cfg_index <= CFG_START);
  assign out_free = !out_valid_r || out_ready;

  // block input words: constants, key, counter, nonce
  always_comb begin
    init_w[0] = SIGMA0;
    init_w[1] = SIGMA1;
    init_w[2] = SIGMA2;
    init_w[3] = SIGMA3;
    for (int i = 0; i < 4; i++) begin
      init_w[4 + 2 * i] = key_r[i][31:0];
      init_w[5 + 2 * i] = key_r[i][63:32];
    end
    init_w[12] = counter_r;
    init_w[13] = nonce_lo_r[31:0];
    init_w[14] = nonce_lo_r[63:32];
    init_w[15] = nonce_hi_r;
  end

  // feed-forward add, one word per STORE cycle
  assign ff_word = work_w[store_idx_r] + init_w[store_idx_r];

  ccsc_round_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl_i (core_ctrl),
    .init_i (init_w),
    .work_o (work_w),
    .stat_o (core_stat)
  );

  // ---- FSM next state ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = pos_r[6] ? ST_GEN : ST_XOR;
      ST_GEN:   if (core_stat.done) state_nxt = ST_STORE;
      ST_STORE: if (store_idx_r == LAST_WORD) state_nxt = ST_FETCH;
      ST_FETCH: state_nxt = ST_XOR;
      ST_XOR:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ---- FSM outputs ----
  always_comb begin
    in_ready        = (state_r == ST_IDLE);
    core_ctrl.start = (state_r == ST_IDLE) && in_valid && pos_r[6];
    rd_en           = ((state_r == ST_IDLE) && in_valid && !pos_r[6])
                   || (state_r == ST_FETCH);
    mem_we          = (state_r == ST_STORE);
    out_load        = (state_r == ST_XOR) && out_free;
  end

  // keystream RAM: written only in STORE, read only in IDLE/FETCH, so the
  // same entry is never read and written in one cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ks_mem[store_idx_r] <= ff_word;
    end
    if (rd_en) begin
      rd_r <= ks_mem[pos_r[5:2]];
    end
  end

  // byte lane select, little-endian
  always_comb begin
    unique case (pos_r[1:0])
      2'd0:    ks_byte = rd_r[7:0];
      2'd1:    ks_byte = rd_r[15:8];
      2'd2:    ks_byte = rd_r[23:16];
      2'd3:    ks_byte = rd_r[31:24];
      default: ks_byte = rd_r[7:0];
    endcase
  end

  // ---- configuration registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r       <= '0;
      nonce_lo_r  <= '0;
      nonce_hi_r  <= '0;
      start_ctr_r <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        CFG_KEY0:     key_r[0]    <= cfg_data;
        CFG_KEY1:     key_r[1]    <= cfg_data;
        CFG_KEY2:     key_r[2]    <= cfg_data;
        CFG_KEY3:     key_r[3]    <= cfg_data;
        CFG_NONCE_LO: nonce_lo_r  <= cfg_data;
        CFG_NONCE_HI: nonce_hi_r  <= cfg_data[31:0];
        CFG_START:    start_ctr_r <= cfg_data[31:0];
        default:      ;  // unmapped index: ignored
      endcase
    end
  end

  // ---- stream control state ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      counter_r   <= '0;
      pos_r       <= 7'd64;
      store_idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_hit) begin
        // any valid write reloads the counter and empties the keystream
        counter_r <= (cfg_index == CFG_START) ? cfg_data[31:0] : start_ctr_r;
        pos_r     <= 7'd64;
      end else if (mem_we && store_idx_r == LAST_WORD) begin
        counter_r <= counter_r + 32'd1;  // wraps silently
        pos_r     <= '0;
      end else if (out_load) begin
        pos_r <= pos_r + 7'd1;
      end
      if (mem_we) begin
        store_idx_r <= store_idx_r + 4'd1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r <= in_data;
    end
    if (out_load) begin
      out_r.result_byte <= in_r.data_byte ^ ks_byte;
      out_r.last_out    <= in_r.last_in;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---- assertions ----
  a_ram_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && rd_en))
    else $error("keystream RAM read and write in same cycle");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    !(pos_r[6] && (pos_r[5:0] != 6'd0)))
    else $error("keystream position beyond 64");

  a_xor_has_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !pos_r[6])
    else $error("result produced from empty keystream");

  a_start_gen: assert property (@(posedge clk) disable iff (!rst_n)
    core_ctrl.start |=> state_r == ST_GEN)
    else $error("round core started outside block generation");

  a_done_in_gen: assert property (@(posedge clk) disable iff (!rst_n)
    core_stat.done |-> state_r == ST_GEN)
    else $error("round core finished while not generating");

  a_busy_in_gen: assert property (@(posedge clk) disable iff (!rst_n)
    core_stat.busy |-> state_r == ST_GEN)
    else $error("round core running while not generating");

endmodule

FILE: bench/ccsc_keystream_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ccsc_keystream_check - result checker for the ChaCha20 stream cipher unit
// Tracks config writes and input beats, regenerates the keystream on its
// own and compares every output beat against the oldest prediction.
// ----------------------------------------------------------------------------
module ccsc_keystream_check (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  ccsc_pkg::in_beat_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  ccsc_pkg::out_beat_t           out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [ccsc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ccsc_pkg::CfgDataW-1:0] cfg_data,
  output int unsigned                   mismatches,
  output int unsigned                   results_seen,
  output int unsigned                   blocks_made
);

  localparam int unsigned NumRegs    = int'(ccsc_pkg::CFG_START) + 1;
  localparam int unsigned BlockBytes = 64;

  logic [ccsc_pkg::CfgDataW-1:0] cipher_regs [NumRegs];
  ccsc_pkg::word_t               block_ctr;
  ccsc_pkg::block_t              ks_block;
  logic [6:0]                    ks_pos;     // 64 = keystream used up
  ccsc_pkg::out_beat_t           cipher_q [$];

  function automatic ccsc_pkg::word_t rot_left(ccsc_pkg::word_t v, int unsigned n);
    logic [63:0] dbl;
    dbl = {v, v} << n;
    return dbl[63:32];
  endfunction

  function automatic ccsc_pkg::block_t quarter_mix(ccsc_pkg::block_t s,
                                                   int a, int b, int c, int d);
    s[a] = s[a] + s[b]; s[d] = rot_left(s[d] ^ s[a], 16);
    s[c] = s[c] + s[d]; s[b] = rot_left(s[b] ^ s[c], 12);
    s[a] = s[a] + s[b]; s[d] = rot_left(s[d] ^ s[a], 8);
    s[c] = s[c] + s[d]; s[b] = rot_left(s[b] ^ s[c], 7);
    return s;
  endfunction

  // one 64-byte keystream block for the current key/nonce and given counter
  function automatic ccsc_pkg::block_t keystream_block(ccsc_pkg::word_t ctr);
    ccsc_pkg::block_t seed;
    ccsc_pkg::block_t mixed;
    int k;
    seed[0] = ccsc_pkg::SIGMA0;
    seed[1] = ccsc_pkg::SIGMA1;
    seed[2] = ccsc_pkg::SIGMA2;
    seed[3] = ccsc_pkg::SIGMA3;
    for (k = int'(ccsc_pkg::CFG_KEY0); k <= int'(ccsc_pkg::CFG_KEY3); k++) begin
      seed[4 + 2 * k] = cipher_regs[k][31:0];
      seed[5 + 2 * k] = cipher_regs[k][63:32];
    end
    seed[12] = ctr;
    seed[13] = cipher_regs[ccsc_pkg::CFG_NONCE_LO][31:0];
    seed[14] = cipher_regs[ccsc_pkg::CFG_NONCE_LO][63:32];
    seed[15] = cipher_regs[ccsc_pkg::CFG_NONCE_HI][31:0];
    mixed = seed;
    for (k = 0; k < int'(ccsc_pkg::NumRounds) / 2; k++) begin
      mixed = quarter_mix(mixed, 0, 4, 8, 12);
      mixed = quarter_mix(mixed, 1, 5, 9, 13);
      mixed = quarter_mix(mixed, 2, 6, 10, 14);
      mixed = quarter_mix(mixed, 3, 7, 11, 15);
      mixed = quarter_mix(mixed, 0, 5, 10, 15);
      mixed = quarter_mix(mixed, 1, 6, 11, 12);
      mixed = quarter_mix(mixed, 2, 7, 8, 13);
      mixed = quarter_mix(mixed, 3, 4, 9, 14);
    end
    for (k = 0; k < int'(ccsc_pkg::NumWords); k++) begin
      mixed[k] = mixed[k] + seed[k];
    end
    return mixed;
  endfunction

  always @(posedge clk) begin
    ccsc_pkg::out_beat_t want;
    ccsc_pkg::word_t     ks_word;
    logic [7:0]          ks_byte;
    int unsigned         errs;
    errs = 0;
    if (!rst_n) begin
      foreach (cipher_regs[i]) cipher_regs[i] = '0;
      block_ctr = '0;
      ks_block  = '0;
      ks_pos    = 7'(BlockBytes);
      cipher_q.delete();
      mismatches   <= 0;
      results_seen <= 0;
      blocks_made  <= 0;
    end else begin
      // output side first: a beat accepted now can't belong to this edge's input
      if (out_valid && out_ready) begin
        if (cipher_q.size() == 0) begin
          $error("output beat with nothing outstanding: result_byte %02h last_out %0b",
                 out_data.result_byte, out_data.last_out);
          errs++;
        end else begin
          want = cipher_q.pop_front();
          if (out_data.result_byte !== want.result_byte) begin
            $error("result_byte: expected %02h, got %02h",
                   want.result_byte, out_data.result_byte);
            errs++;
          end
          if (out_data.last_out !== want.last_out) begin
            $error("last_out: expected %0b, got %0b", want.last_out, out_data.last_out);
            errs++;
          end
          results_seen <= results_seen + 1;
        end
      end

      // writes to a real register reload the counter and empty the keystream;
      // the unused index is dropped without side effects
      if (cfg_valid && cfg_ready && cfg_index <= ccsc_pkg::CFG_START) begin
        cipher_regs[cfg_index] = (cfg_index >= ccsc_pkg::CFG_NONCE_HI) ?
                                 {32'h0, cfg_data[31:0]} : cfg_data;
        block_ctr = cipher_regs[ccsc_pkg::CFG_START][31:0];
        ks_pos    = 7'(BlockBytes);
      end

      if (in_valid && in_ready) begin
        if (ks_pos >= 7'(BlockBytes)) begin
          ks_block  = keystream_block(block_ctr);
          block_ctr = block_ctr + 32'd1;   // wraps silently
          ks_pos    = '0;
          blocks_made <= blocks_made + 1;
        end
        ks_word = ks_block[ks_pos[5:2]];
        ks_byte = ks_word[8 * ks_pos[1:0] +: 8];
        ks_pos  = ks_pos + 7'd1;
        want.result_byte = in_data.data_byte ^ ks_byte;
        want.last_out    = in_data.last_in;
        cipher_q.push_back(want);
      end
      mismatches <= mismatches + errs;
    end
  end

endmodule

FILE: bench/chacha20_stream_cipher_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_unit_tb - regression bench for the ChaCha20 unit
// Directed bytes under default, RFC 8439 and extreme key/nonce/counter
// settings, then random phases of config writes and byte traffic with
// bursty input and a stalling receiver. A separate checker predicts and
// compares every output beat; this top only drives and reports.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_unit_tb;

  localparam int unsigned NumRegs      = int'(ccsc_pkg::CFG_START) + 1;
  localparam int unsigned DirectedCnt  = 235;
  localparam int unsigned RandomCnt    = 1415;
  localparam int unsigned IdleLimit    = 2000;  // block refill plus stalls, many times over
  localparam int unsigned TailCycles   = 120;   // about one block refill
  localparam logic [ccsc_pkg::CfgIdxW-1:0] CfgIdxUnused = 3'd7;

  // receiver back-pressure modes
  typedef enum logic [1:0] {
    RX_OPEN,     // always ready
    RX_CHOPPY,   // ready half the time
    RX_SPARSE    // ready one cycle in four on average
  } rx_mode_t;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  ccsc_pkg::in_beat_t            in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  ccsc_pkg::out_beat_t           out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [ccsc_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [ccsc_pkg::CfgDataW-1:0] cfg_data  = '0;

  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned blocks_made;

  // stimulus bookkeeping
  int unsigned bytes_sent   = 0;
  int unsigned cfg_writes   = 0;
  int unsigned unused_hits  = 0;
  int unsigned phases       = 0;
  int unsigned burst_left   = 0;
  logic        calm         = 1'b0;   // sender runs with no gaps this phase
  int unsigned quiet_cycles = 0;
  rx_mode_t    rx_mode      = RX_OPEN;
  int unsigned rx_left      = 0;

  logic [ccsc_pkg::CfgDataW-1:0] setting [NumRegs];

  wire any_beat = (in_valid && in_ready) || (out_valid && out_ready) ||
                  (cfg_valid && cfg_ready);

  always #5 clk = ~clk;

  chacha20_stream_cipher_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ccsc_keystream_check u_keystream_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .results_seen (results_seen),
    .blocks_made  (blocks_made)
  );

  // Receiver: switches between back-pressure modes at random intervals
  // so stalls land on refills, XOR stage and idle alike.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_left <= $urandom_range(16, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
      default:   out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Watchdog: a run that stops moving beats for too long has hung.
  always @(posedge clk) begin
    if (!rst_n || any_beat) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("Stalled after %0d bytes sent, %0d results checked.",
               bytes_sent, results_seen);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one input beat and hold it until accepted. Bursts of random
  // length are separated by random gaps unless the phase is calm. Valid is
  // left high afterwards so back-to-back beats never toggle it.
  task automatic send_byte(input logic [7:0] data_byte, input logic last_in);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = calm ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_data  <= {data_byte, last_in};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Drop valid and wait for every outstanding result to come back.
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (results_seen != bytes_sent) @(posedge clk);
  endtask

  // One config beat; valid stays high for a following write, caller drops it.
  task automatic cfg_write(input logic [ccsc_pkg::CfgIdxW-1:0] idx,
                           input logic [ccsc_pkg::CfgDataW-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    if (idx == CfgIdxUnused) unused_hits++;
  endtask

  // Write every register from the setting array; caller drops valid.
  task automatic program_setting();
    int i;
    for (i = int'(ccsc_pkg::CFG_KEY0); i <= int'(ccsc_pkg::CFG_START); i++) begin
      cfg_write(ccsc_pkg::CfgIdxW'(i), setting[i]);
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    int          n;
    int          i;
    int unsigned kind;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part --------------------------------------------------
    // reset defaults: all-zero key and nonce, counter 0
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h55, 1'b0);
    drain();

    // RFC 8439 encryption example: key 00..1f, nonce ...4a..., counter 1
    setting[ccsc_pkg::CFG_KEY0]     = 64'h0706_0504_0302_0100;
    setting[ccsc_pkg::CFG_KEY1]     = 64'h0f0e_0d0c_0b0a_0908;
    setting[ccsc_pkg::CFG_KEY2]     = 64'h1716_1514_1312_1110;
    setting[ccsc_pkg::CFG_KEY3]     = 64'h1f1e_1d1c_1b1a_1918;
    setting[ccsc_pkg::CFG_NONCE_LO] = 64'h4a00_0000_0000_0000;
    setting[ccsc_pkg::CFG_NONCE_HI] = 64'h0;
    setting[ccsc_pkg::CFG_START]    = 64'h1;
    program_setting();
    cfg_valid <= 1'b0;
    for (i = 0; i < 12; i++) send_byte(8'($urandom), (i == 11));
    drain();

    // write to the unused index mid-block: must not restart the keystream
    cfg_write(CfgIdxUnused, rand64());
    cfg_valid <= 1'b0;
    for (i = 0; i < 4; i++) send_byte(8'($urandom), 1'b0);
    drain();

    // real write mid-block: keystream restarts at byte 0 of the counter block
    cfg_write(ccsc_pkg::CFG_START, 64'h1);
    cfg_valid <= 1'b0;
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h7F, 1'b0);
    drain();

    // --- extremes --------------------------------------------------------
    // all ones, counter at its top: the second block wraps the counter to 0.
    // Upper halves of the 32-bit registers are set too and must be ignored.
    foreach (setting[j]) setting[j] = '1;
    program_setting();
    cfg_valid <= 1'b0;
    for (i = 0; i < 140; i++) send_byte(8'($urandom), ($urandom_range(0, 7) == 0));
    drain();

    foreach (setting[j]) setting[j] = '0;
    program_setting();
    cfg_valid <= 1'b0;
    for (i = 0; i < 70; i++) send_byte(8'($urandom), ($urandom_range(0, 7) == 0));
    drain();

    // --- random phases ---------------------------------------------------
    // Every phase boundary is a config write while idle, landing at a random
    // keystream position, so mid-block reloads come up constantly.
    while (bytes_sent < DirectedCnt + RandomCnt) begin
      phases++;
      calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        foreach (setting[j]) setting[j] = '1;
        program_setting();
      end else if (kind == 1) begin
        foreach (setting[j]) setting[j] = '0;
        program_setting();
      end else if (kind == 2) begin
        // counter at the wrap point or a block or two below it
        cfg_write(ccsc_pkg::CFG_START, {$urandom, 32'hFFFF_FFFF - $urandom_range(0, 2)});
      end else begin
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) begin
          cfg_write(ccsc_pkg::CfgIdxW'($urandom_range(int'(ccsc_pkg::CFG_KEY0),
                                                      int'(ccsc_pkg::CFG_START))),
                    rand64());
        end
      end
      if ($urandom_range(0, 5) == 0) cfg_write(CfgIdxUnused, rand64());
      cfg_valid <= 1'b0;

      n = ($urandom_range(0, 7) == 0) ? $urandom_range(130, 200) : $urandom_range(1, 100);
      for (i = 0; i < n; i++) send_byte(8'($urandom), ($urandom_range(0, 7) == 0));
      drain();
    end

    // let any trailing activity settle before the verdict
    repeat (TailCycles) @(posedge clk);

    $display("Ran %0d bytes over %0d random phases plus directed/extreme settings, %0d blocks.",
             bytes_sent, phases, blocks_made);
    $display("%0d register writes (%0d to the unused index), %0d results checked.",
             cfg_writes, unused_hits, results_seen);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
